// ===== rtl/rrs_pkg.sv =====
// Shared widths, latencies and word types for the refraction pipeline.
// No dependencies; imported by every rtl module of the block but rrs_delay.
package rrs_pkg;

    localparam int VEC_W     = 32;   // direction component width
    localparam int IDX_W     = 23;   // refractive index width, Q3.20
    localparam int WORD_W    = 64;   // internal scalar width
    localparam int MUL_LAT   = 5;    // register stages in rrs_mulq
    localparam int SQ_LAT    = 32;   // one root bit per stage, radicand < 2^63
    localparam int S_TDATA_W = 240;
    localparam int M_TDATA_W = 96;

    localparam logic [WORD_W-1:0] SAT_LIM = 64'd1 << 61;

    typedef logic signed [WORD_W-1:0] word_t;
    typedef logic        [WORD_W-1:0] uword_t;

endpackage

// ===== rtl/rrs_delay.sv =====
// Enabled shift line that delays a payload word by a fixed number of stages.
// Depends on nothing; stalls with the pipeline enable.
module rrs_delay #(
    parameter int W = 64,
    parameter int D = 1
) (
    input  logic         aclk,
    input  logic         en,
    input  logic [W-1:0] d,
    output logic [W-1:0] q
);

    logic [W-1:0] sr_reg [D];

    always_ff @(posedge aclk) begin
        if (en) begin
            sr_reg[0] <= d;
            for (int k = 1; k < D; k++) begin
                sr_reg[k] <= sr_reg[k-1];
            end
        end
    end

    assign q = sr_reg[D-1];

endmodule

// ===== rtl/rrs_mulq.sv =====
// Pipelined fixed-point multiply: floor(a*b / 2^FRAC_BITS), clamped to +-2^61.
// Uses rrs_pkg; 64x64 product built from four 32x32 partial products.
module rrs_mulq #(
    parameter int FRAC_BITS = 30
) (
    input  logic          aclk,
    input  logic          en,
    input  rrs_pkg::word_t a,
    input  rrs_pkg::word_t b,
    output rrs_pkg::word_t p
);
    import rrs_pkg::*;

    localparam logic [127:0] FMASK = (128'd1 << FRAC_BITS) - 128'd1;

    logic         neg1_reg, neg2_reg, neg3_reg, neg4_reg;
    uword_t       ua_reg, ub_reg;
    uword_t       pp00_reg, pp01_reg, pp10_reg, pp11_reg;
    logic [127:0] prod_reg;
    logic [61:0]  mag_reg;
    word_t        p_reg;

    uword_t       ua_next, ub_next;
    uword_t       pp00_next, pp01_next, pp10_next, pp11_next;
    logic [127:0] prod_next, shq;
    logic         rem;
    logic [61:0]  mag_next;

    always_comb begin
        ua_next   = a[WORD_W-1] ? uword_t'(-a) : uword_t'(a);
        ub_next   = b[WORD_W-1] ? uword_t'(-b) : uword_t'(b);
        pp00_next = ua_reg[31:0]  * ub_reg[31:0];
        pp01_next = ua_reg[31:0]  * ub_reg[63:32];
        pp10_next = ua_reg[63:32] * ub_reg[31:0];
        pp11_next = ua_reg[63:32] * ub_reg[63:32];
        prod_next = {64'd0, pp00_reg} + ({64'd0, pp01_reg} << 32)
                  + ({64'd0, pp10_reg} << 32) + {pp11_reg, 64'd0};
        // floor for negative results: round the magnitude up on a remainder
        rem       = |(prod_reg & FMASK);
        shq       = (prod_reg >> FRAC_BITS) + {127'd0, neg3_reg & rem};
        mag_next  = (shq > {64'd0, SAT_LIM}) ? SAT_LIM[61:0] : shq[61:0];
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            neg1_reg <= a[WORD_W-1] ^ b[WORD_W-1];
            ua_reg   <= ua_next;
            ub_reg   <= ub_next;
            neg2_reg <= neg1_reg;
            pp00_reg <= pp00_next;
            pp01_reg <= pp01_next;
            pp10_reg <= pp10_next;
            pp11_reg <= pp11_next;
            neg3_reg <= neg2_reg;
            prod_reg <= prod_next;
            neg4_reg <= neg3_reg;
            mag_reg  <= mag_next;
            p_reg    <= neg4_reg ? -word_t'({2'b00, mag_reg}) : word_t'({2'b00, mag_reg});
        end
    end

    assign p = p_reg;

endmodule

// ===== rtl/rrs_div.sv =====
// Pipelined restoring divider for b = floor(n1 * 2^FRAC_BITS / n2).
// Uses rrs_pkg; one quotient bit per stage, zero divisor taken as one.
module rrs_div #(
    parameter int FRAC_BITS = 30
) (
    input  logic                      aclk,
    input  logic                      en,
    input  logic [rrs_pkg::IDX_W-1:0] n1,
    input  logic [rrs_pkg::IDX_W-1:0] n2,
    output rrs_pkg::word_t            q
);
    import rrs_pkg::*;

    localparam int QW = IDX_W + FRAC_BITS;

    logic [IDX_W-1:0] rem_reg [QW];
    logic [QW-1:0]    nq_reg  [QW];
    logic [IDX_W-1:0] dvs_reg [QW];

    logic [IDX_W-1:0] dvs_in;

    // shift one numerator bit into the remainder, one quotient bit into the word
    function automatic logic [IDX_W+QW-1:0] div_step(
        input logic [IDX_W-1:0] r, input logic [QW-1:0] nq, input logic [IDX_W-1:0] dv
    );
        logic [IDX_W:0]   ext;
        logic [IDX_W+1:0] diff;
        logic             ge;
        ext  = {r, nq[QW-1]};
        diff = {1'b0, ext} - {2'b00, dv};
        ge   = !diff[IDX_W+1];
        return {ge ? diff[IDX_W-1:0] : ext[IDX_W-1:0], nq[QW-2:0], ge};
    endfunction

    assign dvs_in = (n2 == '0) ? IDX_W'(1) : n2;

    always_ff @(posedge aclk) begin
        if (en) begin
            {rem_reg[0], nq_reg[0]} <= div_step('0, {n1, FRAC_BITS'(0)}, dvs_in);
            dvs_reg[0] <= dvs_in;
            for (int k = 1; k < QW; k++) begin
                {rem_reg[k], nq_reg[k]} <= div_step(rem_reg[k-1], nq_reg[k-1], dvs_reg[k-1]);
                dvs_reg[k] <= dvs_reg[k-1];
            end
        end
    end

    assign q = word_t'({{(WORD_W-QW){1'b0}}, nq_reg[QW-1]});

endmodule

// ===== rtl/rrs_sqrt.sv =====
// Pipelined integer square root, floor(sqrt(x)) for x < 2^63.
// Uses rrs_pkg; digit-by-digit method, one result bit per stage.
module rrs_sqrt (
    input  logic                       aclk,
    input  logic                       en,
    input  rrs_pkg::uword_t            x,
    output logic [rrs_pkg::VEC_W-1:0]  root
);
    import rrs_pkg::*;

    uword_t x_reg [SQ_LAT];
    uword_t r_reg [SQ_LAT];

    function automatic logic [2*WORD_W-1:0] sq_step(
        input uword_t xv, input uword_t rv, input uword_t bv
    );
        uword_t trial;
        trial = rv + bv;
        if (xv >= trial) begin
            return {xv - trial, (rv >> 1) + bv};
        end
        return {xv, rv >> 1};
    endfunction

    always_ff @(posedge aclk) begin
        if (en) begin
            {x_reg[0], r_reg[0]} <= sq_step(x, '0, uword_t'(1) << 62);
            for (int k = 1; k < SQ_LAT; k++) begin
                {x_reg[k], r_reg[k]} <= sq_step(x_reg[k-1], r_reg[k-1],
                                                uword_t'(1) << (62 - 2*k));
            end
        end
    end

    assign root = r_reg[SQ_LAT-1][VEC_W-1:0];

endmodule

// ===== rtl/ray_refraction_snell_tir.sv =====
// Ray refraction by vector Snell's law with total internal reflection.
// The pipeline depth is set by the index divider (23 + FRAC_BITS stages)
// and the square root (32 stages) in series.
// Throughput: one transfer per cycle; a stalled output freezes the whole pipeline.
// Reset: aresetn (synchronous, active low) clears the stage valid bits only.
module ray_refraction_snell_tir #(
    parameter int FRAC_BITS = 30
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // incident_x, incident_y, incident_z, normal_x, normal_y, normal_z,
    // index_from, index_to, 2 zero pad bits
    input  logic [rrs_pkg::S_TDATA_W-1:0] s_tdata,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // out_x, out_y, out_z
    output logic [rrs_pkg::M_TDATA_W-1:0] m_tdata,
    // total_reflection
    output logic                          m_tuser
);
    import rrs_pkg::*;

    localparam int QW  = IDX_W + FRAC_BITS;
    localparam int TB  = QW;                    // b out of the divider
    localparam int TD  = TB + 2*MUL_LAT + 1;    // d2 registered
    localparam int TS  = TD + SQ_LAT;           // root available
    localparam int LAT = TS + 2 + MUL_LAT;      // output register

    localparam word_t ONE    = word_t'(64'd1 << FRAC_BITS);
    localparam word_t DMAX   = word_t'((64'd1 << (63 - FRAC_BITS)) - 64'd1);
    localparam word_t SAT_P  = word_t'(SAT_LIM);
    localparam word_t V_MAX  = word_t'(64'h0000_0000_7FFF_FFFF);
    localparam word_t V_MIN  = word_t'(64'hFFFF_FFFF_8000_0000);

    function automatic word_t clamp61(input word_t x);
        if (x > SAT_P) return SAT_P;
        if (x < -SAT_P) return -SAT_P;
        return x;
    endfunction

    function automatic logic [VEC_W-1:0] pack32(input word_t x);
        if (x > V_MAX) return V_MAX[VEC_W-1:0];
        if (x < V_MIN) return V_MIN[VEC_W-1:0];
        return x[VEC_W-1:0];
    endfunction

    logic en;
    logic [LAT-1:0] vld_reg;

    logic signed [VEC_W-1:0] in_v [3];
    logic signed [VEC_W-1:0] in_n [3];
    logic [IDX_W-1:0]        in_n1, in_n2;
    word_t                   dot_p [3];

    word_t prod_reg [3];
    word_t csum_reg, cfix_reg;
    logic  nflip_reg;
    logic signed [WORD_W+1:0] sum66, sh66;

    word_t cc, t_in, t_d, bq, b2, c_b, bc, mm, d2;
    word_t d2sat_reg, d2sat_next;
    logic  tir_reg;
    logic [VEC_W-1:0] root;

    word_t bc_s, c_s, asum, opa_reg, opa_next, b_d;
    logic  tir_s, tir_o, nflip_d;
    logic [6*VEC_W-1:0] vn_d;
    logic [3*VEC_W-1:0] v_o;
    word_t nfix [3], vmul [3], m1 [3], m2 [3], res [3];

    logic [M_TDATA_W-1:0] m_tdata_reg, m_tdata_next;
    logic                 m_tuser_reg;

    assign en       = !vld_reg[LAT-1] || m_tready;
    assign s_tready = en;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            in_v[i]  = s_tdata[i*VEC_W +: VEC_W];
            in_n[i]  = s_tdata[(3+i)*VEC_W +: VEC_W];
            dot_p[i] = in_v[i] * in_n[i];
        end
        in_n1 = s_tdata[6*VEC_W +: IDX_W];
        in_n2 = s_tdata[6*VEC_W+IDX_W +: IDX_W];
        sum66 = (WORD_W+2)'(prod_reg[0]) + (WORD_W+2)'(prod_reg[1])
              + (WORD_W+2)'(prod_reg[2]);
        sh66  = sum66 >>> FRAC_BITS;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[LAT-2:0], s_tvalid};
        end
    end

    // dot product and sign fix: c <= 0, normal flipped when c was non-negative
    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                prod_reg[i] <= dot_p[i];
            end
            csum_reg  <= sh66[WORD_W-1:0];
            cfix_reg  <= csum_reg[WORD_W-1] ? csum_reg : -csum_reg;
            nflip_reg <= !csum_reg[WORD_W-1];
        end
    end

    rrs_div #(.FRAC_BITS(FRAC_BITS)) u_div (
        .aclk(aclk), .en(en), .n1(in_n1), .n2(in_n2), .q(bq)
    );

    rrs_mulq #(.FRAC_BITS(FRAC_BITS)) u_cc (
        .aclk(aclk), .en(en), .a(cfix_reg), .b(cfix_reg), .p(cc)
    );

    assign t_in = ONE - cc;

    rrs_delay #(.W(WORD_W), .D(QW - 3)) u_dly_t (
        .aclk(aclk), .en(en), .d(t_in), .q(t_d)
    );
    rrs_delay #(.W(WORD_W), .D(QW - 3)) u_dly_c (
        .aclk(aclk), .en(en), .d(cfix_reg), .q(c_b)
    );

    rrs_mulq #(.FRAC_BITS(FRAC_BITS)) u_b2 (
        .aclk(aclk), .en(en), .a(bq), .b(bq), .p(b2)
    );
    rrs_mulq #(.FRAC_BITS(FRAC_BITS)) u_bc (
        .aclk(aclk), .en(en), .a(bq), .b(c_b), .p(bc)
    );
    rrs_mulq #(.FRAC_BITS(FRAC_BITS)) u_bt (
        .aclk(aclk), .en(en), .a(b2), .b(t_d), .p(mm)
    );

    // d2 < 0 means total internal reflection; otherwise cap for the root
    always_comb begin
        d2 = ONE - mm;
        if (d2[WORD_W-1]) begin
            d2sat_next = '0;
        end else if (d2 > DMAX) begin
            d2sat_next = DMAX;
        end else begin
            d2sat_next = d2;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            d2sat_reg <= d2sat_next;
            tir_reg   <= d2[WORD_W-1];
        end
    end

    rrs_sqrt u_sqrt (
        .aclk(aclk), .en(en), .x(uword_t'(d2sat_reg) << FRAC_BITS), .root(root)
    );

    rrs_delay #(.W(WORD_W), .D(MUL_LAT + 1 + SQ_LAT)) u_dly_bc (
        .aclk(aclk), .en(en), .d(bc), .q(bc_s)
    );
    rrs_delay #(.W(WORD_W), .D(TS - TB)) u_dly_cs (
        .aclk(aclk), .en(en), .d(c_b), .q(c_s)
    );
    rrs_delay #(.W(1), .D(SQ_LAT)) u_dly_tir_s (
        .aclk(aclk), .en(en), .d(tir_reg), .q(tir_s)
    );
    rrs_delay #(.W(1), .D(SQ_LAT + 1 + MUL_LAT)) u_dly_tir_o (
        .aclk(aclk), .en(en), .d(tir_reg), .q(tir_o)
    );

    // root added only when c is exactly zero, subtracted otherwise
    always_comb begin
        if (c_s == '0) begin
            asum = -bc_s + word_t'({32'd0, root});
        end else begin
            asum = -bc_s - word_t'({32'd0, root});
        end
        opa_next = tir_s ? (c_s + c_s) : clamp61(asum);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            opa_reg <= opa_next;
        end
    end

    rrs_delay #(.W(6*VEC_W), .D(TS + 1)) u_dly_vn (
        .aclk(aclk), .en(en), .d(s_tdata[6*VEC_W-1:0]), .q(vn_d)
    );
    rrs_delay #(.W(1), .D(TS - 2)) u_dly_nf (
        .aclk(aclk), .en(en), .d(nflip_reg), .q(nflip_d)
    );
    rrs_delay #(.W(WORD_W), .D(TS + 1 - TB)) u_dly_b (
        .aclk(aclk), .en(en), .d(bq), .q(b_d)
    );
    rrs_delay #(.W(3*VEC_W), .D(MUL_LAT)) u_dly_v (
        .aclk(aclk), .en(en), .d(vn_d[3*VEC_W-1:0]), .q(v_o)
    );

    for (genvar g = 0; g < 3; g++) begin : g_lane
        always_comb begin
            vmul[g] = word_t'($signed(vn_d[g*VEC_W +: VEC_W]));
            nfix[g] = nflip_d ? -word_t'($signed(vn_d[(3+g)*VEC_W +: VEC_W]))
                              :  word_t'($signed(vn_d[(3+g)*VEC_W +: VEC_W]));
        end

        rrs_mulq #(.FRAC_BITS(FRAC_BITS)) u_m1 (
            .aclk(aclk), .en(en), .a(opa_reg), .b(nfix[g]), .p(m1[g])
        );
        rrs_mulq #(.FRAC_BITS(FRAC_BITS)) u_m2 (
            .aclk(aclk), .en(en), .a(b_d), .b(vmul[g]), .p(m2[g])
        );

        // reflection: v - 2c*n; refraction: a*n + b*v
        assign res[g] = tir_o ? word_t'($signed(v_o[g*VEC_W +: VEC_W])) - m1[g]
                              : m1[g] + m2[g];
        assign m_tdata_next[g*VEC_W +: VEC_W] = pack32(res[g]);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m_tdata_reg <= m_tdata_next;
            m_tuser_reg <= tir_o;
        end
    end

    assign m_tvalid = vld_reg[LAT-1];
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

// ===== verif/rrs_checker.sv =====
// Checker for ray_refraction_snell_tir: watches both stream channels, predicts each
// refracted or reflected direction and compares it field by field. Needs rrs_pkg.
`timescale 1ns / 100ps
module rrs_checker #(
    parameter int FRAC_BITS = 30
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    input  logic                          s_tready,
    input  logic [rrs_pkg::S_TDATA_W-1:0] s_tdata,
    input  logic                          m_tvalid,
    input  logic                          m_tready,
    input  logic [rrs_pkg::M_TDATA_W-1:0] m_tdata,
    input  logic                          m_tuser,
    output int                            errors,
    output int                            pending,
    output int                            tir_seen,
    output int                            rays_seen
);
    import rrs_pkg::*;

    typedef struct packed {
        logic signed [31:0] dx;
        logic signed [31:0] dy;
        logic signed [31:0] dz;
        logic               tir;
    } direction_t;

    localparam logic signed [127:0] LIM128 = 128'sd1 <<< 61;

    direction_t dir_q[$];

    function automatic word_t sat61(logic signed [127:0] x);
        if (x > LIM128) return word_t'(LIM128);
        if (x < -LIM128) return word_t'(-LIM128);
        return x[63:0];
    endfunction

    // floor(a*b / 2^F), saturated
    function automatic word_t qmul(word_t a, word_t b);
        logic signed [127:0] p;
        p = a * b;
        p = p >>> FRAC_BITS;
        return sat61(p);
    endfunction

    function automatic uword_t root64(uword_t x);
        uword_t r, bv;
        r = 0;
        bv = 64'd1 << 62;
        while (bv > x) bv = bv >> 2;
        while (bv != 0) begin
            if (x >= r + bv) begin
                x = x - (r + bv);
                r = (r >> 1) + bv;
            end else begin
                r = r >> 1;
            end
            bv = bv >> 2;
        end
        return r;
    endfunction

    function automatic logic signed [31:0] sat32(word_t x);
        if (x > 64'sd2147483647) return 32'sh7fffffff;
        if (x < -64'sd2147483648) return 32'sh80000000;
        return x[31:0];
    endfunction

    function automatic direction_t refract(logic [S_TDATA_W-1:0] d);
        word_t v[3], n[3], c, one, b, b2, t, d2, a, s, dmax, c2x, o[3];
        logic signed [127:0] tmp, acc;
        uword_t n1, n2;
        direction_t r;
        // three 2^62 products overflow 64 bits, so sum wide
        acc = 0;
        for (int i = 0; i < 3; i++) begin
            v[i] = word_t'($signed(d[32*i +: 32]));
            n[i] = word_t'($signed(d[96 + 32*i +: 32]));
            acc = acc + v[i] * n[i];
        end
        n1 = uword_t'(d[192 +: IDX_W]);
        n2 = uword_t'(d[215 +: IDX_W]);
        c = word_t'(acc >>> FRAC_BITS);
        if (c >= 0) begin
            for (int i = 0; i < 3; i++) n[i] = -n[i];
            c = -c;
        end
        one = word_t'(64'sd1 <<< FRAC_BITS);
        if (n2 == 0) n2 = 1;
        b = word_t'((n1 << FRAC_BITS) / n2);
        b2 = qmul(b, b);
        tmp = one - qmul(c, c);
        t = sat61(tmp);
        tmp = one - qmul(b2, t);
        d2 = sat61(tmp);
        if (d2 >= 0) begin
            dmax = (64'sd1 <<< (63 - FRAC_BITS)) - 1;
            if (d2 > dmax) d2 = dmax;
            s = word_t'(root64(uword_t'(d2) << FRAC_BITS));
            // grazing ray keeps the positive root
            if (c == 0) tmp = -qmul(b, c) + s;
            else tmp = -qmul(b, c) - s;
            a = sat61(tmp);
            for (int i = 0; i < 3; i++) o[i] = qmul(a, n[i]) + qmul(b, v[i]);
            r.tir = 1'b0;
        end else begin
            c2x = c + c;
            for (int i = 0; i < 3; i++) o[i] = v[i] - qmul(c2x, n[i]);
            r.tir = 1'b1;
        end
        r.dx = sat32(o[0]);
        r.dy = sat32(o[1]);
        r.dz = sat32(o[2]);
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("[%0t] %s: got %h, expected %h", $realtime, what, got, want);
        errors++;
    endtask

    initial begin
        errors = 0;
        pending = 0;
        tir_seen = 0;
        rays_seen = 0;
    end

    always @(posedge aclk) begin
        direction_t w;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                rays_seen++;
                if (dir_q.size() == 0) begin
                    report_mismatch("unexpected transfer", m_tdata[31:0], 32'h0);
                end else begin
                    w = dir_q.pop_front();
                    if (w.tir) tir_seen++;
                    if (m_tdata[31:0] !== w.dx) report_mismatch("out_x", m_tdata[31:0], w.dx);
                    if (m_tdata[63:32] !== w.dy) report_mismatch("out_y", m_tdata[63:32], w.dy);
                    if (m_tdata[95:64] !== w.dz) report_mismatch("out_z", m_tdata[95:64], w.dz);
                    if (m_tuser !== w.tir)
                        report_mismatch("total_reflection", {31'b0, m_tuser}, {31'b0, w.tir});
                end
            end
            if (s_tvalid && s_tready) dir_q.push_back(refract(s_tdata));
            pending = dir_q.size();
        end
    end

endmodule

// ===== verif/tb.sv =====
// Top of the ray_refraction_snell_tir testbench: clock, reset, ray stimulus and verdict.
// Depends on rrs_pkg, the block itself and rrs_checker.
`timescale 1ns / 100ps
module tb;
    import rrs_pkg::*;

    localparam int LIMIT = 400000;
    localparam logic signed [31:0] ONE = 32'sh40000000;
    localparam logic [22:0] IDX1 = 23'h100000;
    localparam logic [22:0] IDX4 = 23'h400000;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [S_TDATA_W-1:0] s_tdata = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic m_tuser;
    int errors, pending, tir_seen, rays_seen;
    int cycles = 0;
    bit idle_on = 1'b1;

    ray_refraction_snell_tir dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

    rrs_checker chk (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .errors(errors), .pending(pending), .tir_seen(tir_seen), .rays_seen(rays_seen)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles > LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding", cycles, pending);
            $display("ray_refraction_snell_tir: mismatch");
            $finish;
        end
    end

    always @(negedge aclk)
        m_tready <= idle_on ? ($urandom_range(99) >= 10) : 1'b1;

    task automatic send_ray(logic signed [31:0] vx, vy, vz, nx, ny, nz,
                            logic [22:0] n1, n2);
        // before about four rays in a hundred, a random idle gap with s_tvalid low
        if (idle_on && $urandom_range(99) < 4) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {2'b00, n2, n1, nz, ny, nx, vz, vy, vx};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        @(negedge aclk);
    endtask

    function automatic logic signed [31:0] near_unit();
        return $signed($urandom_range(32'h80000000, 0)) - ONE;
    endfunction

    initial begin
        logic signed [31:0] r[6];
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // head-on, grazing, same-side normal, total reflection, zero index_to
        send_ray(0, 0, -ONE, 0, 0, ONE, IDX1, IDX1);
        send_ray(0, 0, -ONE, 0, 0, ONE, IDX1, 23'h180000);
        send_ray(ONE, 0, 0, 0, 0, ONE, IDX4, IDX1);
        send_ray(0, 0, ONE, 0, 0, ONE, 23'h180000, IDX1);
        send_ray(32'sh2d413ccd, 0, -32'sh2d413ccd, 0, 0, ONE, IDX4, IDX1);
        send_ray(32'sh2d413ccd, 0, -32'sh2d413ccd, 0, 0, ONE, IDX1, IDX4);
        send_ray(0, ONE, -ONE, 0, 0, ONE, IDX1, 23'h0);
        send_ray(32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff,
                 32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 23'h7fffff, 23'h7fffff);
        send_ray(32'sh80000000, 32'sh80000000, 32'sh80000000,
                 32'sh80000000, 32'sh80000000, 32'sh80000000, 23'h0, 23'h1);
        send_ray(32'sh80000000, 32'sh7fffffff, 32'sh80000000,
                 32'sh7fffffff, 32'sh80000000, 32'sh7fffffff, 23'h7fffff, 23'h0);
        // huge c drives d2 far past the root's range
        send_ray(32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff,
                 32'sh80000000, 32'sh80000000, 32'sh80000000, IDX1, IDX4);
        send_ray(0, 0, 0, 0, 0, 0, IDX1, IDX1);
        send_ray(ONE, ONE, ONE, 0, ONE, 0, IDX4, IDX4);
        send_ray(-ONE, 0, 0, ONE, 0, 0, 23'h7fffff, 23'h1);
        s_tvalid <= 1'b0;

        // hold off until the pipeline has drained
        while (pending != 0) @(negedge aclk);

        for (int k = 0; k < 1650; k++) begin
            idle_on = !(k >= 600 && k < 900);
            if ($urandom_range(99) < 25) begin
                for (int j = 0; j < 6; j++) r[j] = $signed($urandom());
                send_ray(r[0], r[1], r[2], r[3], r[4], r[5],
                         23'($urandom()), 23'($urandom()));
            end else begin
                send_ray(near_unit(), near_unit(), near_unit(),
                         near_unit(), near_unit(), near_unit(),
                         23'($urandom_range(IDX4, IDX1)), 23'($urandom_range(IDX4, IDX1)));
            end
        end
        s_tvalid <= 1'b0;
        idle_on = 1'b1;

        while (pending != 0) @(negedge aclk);
        repeat (150) @(negedge aclk);

        $display("%0d rays checked, %0d of them totally reflected", rays_seen, tir_seen);
        $display("covered unit and out-of-range vectors, grazing and head-on rays, zero index");
        if (errors == 0 && pending == 0) begin
            $display("ray_refraction_snell_tir: match");
        end else begin
            $display("ray_refraction_snell_tir: mismatch");
        end
        $finish;
    end
endmodule

// ===== ray_refraction_snell_tir.f =====
rtl/rrs_pkg.sv
rtl/rrs_delay.sv
rtl/rrs_mulq.sv
rtl/rrs_div.sv
rtl/rrs_sqrt.sv
rtl/ray_refraction_snell_tir.sv
verif/rrs_checker.sv
verif/tb.sv
